>>> sv/pbd_pkg.sv
// Shared types and constants for the PackBits bitplane image decoder.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pbd_pkg;

    localparam int ADDR_W        = 15;
    localparam int ADDR_SPAN     = 1 << ADDR_W;
    localparam int SEGMENT_BYTES = 40;
    localparam int LINES         = 200;
    localparam int LINE_BYTES    = 160;
    localparam int HEADER_BYTES  = 33;
    localparam int FILL_W        = 6;
    localparam int LINE_W        = 8;
    localparam int RUN_W         = 8;

    localparam logic [7:0] TYPE_COMPRESSED = 8'h80;

    // Pointer correction at the end of a segment: back one line, on one word.
    localparam logic [ADDR_W-1:0] PLANE_ADJ = ADDR_W'(ADDR_SPAN - LINE_BYTES + 2);
    // End of the fourth plane: -160+2, then +160-8 to the next line; net back 6.
    localparam logic [ADDR_W-1:0] LINE_ADJ  = ADDR_W'(ADDR_SPAN - 6);

    typedef struct packed {
        logic load_type;   // type byte: pick mode, arm header count
        logic dec_header;  // header byte skipped
        logic load_run;    // control byte: load run length
        logic latch_byte;  // hold the repeat byte for expansion
        logic dec_run;     // one byte of the run used
        logic put;         // decoded byte write, interleaved address
        logic sel_held;    // put takes the held byte, not the input
        logic last;        // last_of_run for this put
        logic raw_put;     // raw byte write, linear address
        logic emit_err;    // overrun beat
    } pbd_cmd_t;

    typedef struct packed {
        logic out_free;    // output register can take a beat this cycle
        logic header_last; // current header byte is the last one
        logic compressed;  // compressed mode selected by the type byte
        logic is_repeat;   // input control byte is a repeat code
        logic overrun;     // input control byte would overrun the segment
        logic run_is_one;  // one byte of the run left
        logic done_now;    // a put now completes the image
        logic raw_last;    // a raw put now fills the last address
    } pbd_stat_t;

endpackage

`default_nettype wire

>>> sv/pbd_ctrl.sv
// Controller FSM for the PackBits bitplane image decoder.
// Depends on pbd_pkg; drives the datapath commands and the input stall.
`timescale 1ns / 1ps
`default_nettype none

module pbd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire pbd_pkg::pbd_stat_t stat,
    output pbd_pkg::pbd_cmd_t      cmd
);
    import pbd_pkg::*;

    localparam logic [3:0] S_TYPE    = 4'd0;
    localparam logic [3:0] S_HEADER  = 4'd1;
    localparam logic [3:0] S_CONTROL = 4'd2;
    localparam logic [3:0] S_REPEAT  = 4'd3;
    localparam logic [3:0] S_LITERAL = 4'd4;
    localparam logic [3:0] S_RAW     = 4'd5;
    localparam logic [3:0] S_EXPAND  = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;
    localparam logic [3:0] S_HALT    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    always_comb
    begin
        case (state_reg)
            S_EXPAND:       byte_stall = 1'b1;
            S_DONE, S_HALT: byte_stall = 1'b0;
            default:        byte_stall = !stat.out_free;
        endcase
    end

    assign accept = byte_valid && !byte_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_TYPE:
            begin
                if (accept)
                begin
                    cmd.load_type = 1'b1;
                    state_next    = S_HEADER;
                end
            end
            S_HEADER:
            begin
                if (accept)
                begin
                    cmd.dec_header = 1'b1;
                    if (stat.header_last)
                    begin
                        state_next = stat.compressed ? S_CONTROL : S_RAW;
                    end
                end
            end
            S_CONTROL:
            begin
                if (accept)
                begin
                    if (stat.overrun)
                    begin
                        cmd.emit_err = 1'b1;
                        state_next   = S_HALT;
                    end
                    else
                    begin
                        cmd.load_run = 1'b1;
                        state_next   = stat.is_repeat ? S_REPEAT : S_LITERAL;
                    end
                end
            end
            S_REPEAT:
            begin
                // first copy goes out with the beat; a repeat run is at least two
                if (accept)
                begin
                    cmd.put        = 1'b1;
                    cmd.latch_byte = 1'b1;
                    cmd.dec_run    = 1'b1;
                    cmd.last       = stat.run_is_one;
                    if (stat.done_now)
                        state_next = S_DONE;
                    else if (stat.run_is_one)
                        state_next = S_CONTROL;
                    else
                        state_next = S_EXPAND;
                end
            end
            S_LITERAL:
            begin
                if (accept)
                begin
                    cmd.put     = 1'b1;
                    cmd.dec_run = 1'b1;
                    cmd.last    = 1'b1;
                    if (stat.done_now)
                        state_next = S_DONE;
                    else if (stat.run_is_one)
                        state_next = S_CONTROL;
                end
            end
            S_RAW:
            begin
                if (accept)
                begin
                    cmd.raw_put = 1'b1;
                    if (stat.raw_last)
                        state_next = S_DONE;
                end
            end
            S_EXPAND:
            begin
                if (stat.out_free)
                begin
                    cmd.put      = 1'b1;
                    cmd.sel_held = 1'b1;
                    cmd.dec_run  = 1'b1;
                    cmd.last     = stat.run_is_one;
                    if (stat.done_now)
                        state_next = S_DONE;
                    else if (stat.run_is_one)
                        state_next = S_CONTROL;
                end
            end
            S_DONE, S_HALT:
            begin
                state_next = state_reg;
            end
            default:
            begin
                state_next = S_TYPE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_TYPE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> sv/pbd_datapath.sv
// Datapath of the PackBits bitplane image decoder: counters, pointers and
// the output register. Depends on pbd_pkg; commanded by pbd_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module pbd_datapath (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [7:0]                byte_value,
    input  wire pbd_pkg::pbd_cmd_t         cmd,
    output pbd_pkg::pbd_stat_t             stat,
    output logic                           write_valid,
    input  wire logic                      write_stall,
    output logic [pbd_pkg::ADDR_W-1:0]     write_address,
    output logic [7:0]                     write_data,
    output logic                           last_of_run,
    output logic                           image_done,
    output logic                           overrun_error
);
    import pbd_pkg::*;

    logic [5:0]        header_left_reg;
    logic              compressed_reg;
    logic [RUN_W-1:0]  run_left_reg;
    logic [ADDR_W-1:0] write_pointer_reg;
    logic              odd_step_reg;
    logic [FILL_W-1:0] segment_fill_reg;
    logic [1:0]        plane_index_reg;
    logic [LINE_W-1:0] line_index_reg;
    logic [ADDR_W-1:0] raw_count_reg;
    logic [7:0]        held_byte_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;
    logic              out_done_reg;
    logic              out_err_reg;

    logic [8:0]        run_len;
    logic [9:0]        fill_sum;
    logic              seg_end;
    logic              plane_wrap;
    logic [LINE_W-1:0] line_inc;
    logic [ADDR_W-1:0] wp_step;
    logic [ADDR_W-1:0] wp_next;
    logic [7:0]        put_data;

    // run length of a control byte: 257-c for repeat codes, c+1 for literals
    assign run_len  = byte_value[7] ? (9'd257 - {1'b0, byte_value})
                                    : ({1'b0, byte_value} + 9'd1);
    assign fill_sum = {{(10-FILL_W){1'b0}}, segment_fill_reg} + {1'b0, run_len};

    assign seg_end    = (segment_fill_reg == FILL_W'(SEGMENT_BYTES - 1));
    assign plane_wrap = (plane_index_reg == 2'd3);
    assign line_inc   = line_index_reg + LINE_W'(1);
    assign wp_step    = write_pointer_reg + (odd_step_reg ? ADDR_W'(7) : ADDR_W'(1));
    assign wp_next    = !seg_end   ? wp_step
                      : plane_wrap ? wp_step + LINE_ADJ
                      :              wp_step + PLANE_ADJ;
    assign put_data   = cmd.sel_held ? held_byte_reg : byte_value;

    always_comb
    begin
        stat.out_free    = !out_valid_reg || !write_stall;
        stat.header_last = (header_left_reg <= 6'd1);
        stat.compressed  = compressed_reg;
        stat.is_repeat   = byte_value[7];
        stat.overrun     = (fill_sum > 10'(SEGMENT_BYTES));
        stat.run_is_one  = (run_left_reg == RUN_W'(1));
        stat.done_now    = seg_end && plane_wrap && (line_inc == LINE_W'(LINES));
        stat.raw_last    = (raw_count_reg == {ADDR_W{1'b1}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_left_reg   <= 6'(HEADER_BYTES);
            compressed_reg    <= 1'b0;
            run_left_reg      <= '0;
            write_pointer_reg <= '0;
            odd_step_reg      <= 1'b0;
            segment_fill_reg  <= '0;
            plane_index_reg   <= '0;
            line_index_reg    <= '0;
            raw_count_reg     <= '0;
        end
        else
        begin
            if (cmd.load_type)
            begin
                compressed_reg  <= (byte_value == TYPE_COMPRESSED);
                header_left_reg <= 6'(HEADER_BYTES);
            end
            if (cmd.dec_header && header_left_reg != 6'd0)
                header_left_reg <= header_left_reg - 6'd1;
            if (cmd.load_run)
                run_left_reg <= run_len[RUN_W-1:0];
            else if (cmd.dec_run && run_left_reg != '0)
                run_left_reg <= run_left_reg - RUN_W'(1);
            if (cmd.put)
            begin
                write_pointer_reg <= wp_next;
                odd_step_reg      <= !odd_step_reg;
                segment_fill_reg  <= seg_end ? '0 : segment_fill_reg + FILL_W'(1);
                if (seg_end)
                begin
                    plane_index_reg <= plane_index_reg + 2'd1;
                    if (plane_wrap)
                        line_index_reg <= line_inc;
                end
            end
            if (cmd.raw_put)
                raw_count_reg <= raw_count_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_byte)
            held_byte_reg <= byte_value;
    end

    // output register; commands only emit when it can take a beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stat.out_free)
            out_valid_reg <= cmd.put || cmd.raw_put || cmd.emit_err;
    end

    always_ff @(posedge clk)
    begin
        if (stat.out_free)
        begin
            if (cmd.put)
            begin
                out_addr_reg <= write_pointer_reg;
                out_data_reg <= put_data;
                out_last_reg <= cmd.last;
                out_done_reg <= stat.done_now;
                out_err_reg  <= 1'b0;
            end
            else if (cmd.raw_put)
            begin
                out_addr_reg <= raw_count_reg;
                out_data_reg <= byte_value;
                out_last_reg <= 1'b1;
                out_done_reg <= stat.raw_last;
                out_err_reg  <= 1'b0;
            end
            else if (cmd.emit_err)
            begin
                out_addr_reg <= '0;
                out_data_reg <= '0;
                out_last_reg <= 1'b1;
                out_done_reg <= 1'b0;
                out_err_reg  <= 1'b1;
            end
        end
    end

    assign write_valid   = out_valid_reg;
    assign write_address = out_addr_reg;
    assign write_data    = out_data_reg;
    assign last_of_run   = out_last_reg;
    assign image_done    = out_done_reg;
    assign overrun_error = out_err_reg;

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.put, cmd.raw_put, cmd.emit_err}))
        else $error("more than one beat source in a cycle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put || cmd.raw_put || cmd.emit_err) |-> stat.out_free)
        else $error("beat emitted while output register is held");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        segment_fill_reg < FILL_W'(SEGMENT_BYTES))
        else $error("segment fill out of range");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put && !cmd.load_run) |-> (run_left_reg != '0))
        else $error("decoded write with no run left");

    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_last_reg && !out_done_reg))
        else $error("overrun beat carries bad flags");

endmodule

`default_nettype wire

>>> sv/packbits_bitplane_image_decoder_top.sv
// Top level of the PackBits bitplane image decoder.
// Depends on pbd_pkg, pbd_ctrl and pbd_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Takes an image file one byte per beat on the byte channel and gives one
// memory write per beat on the write channel. Header, type and control bytes
// give no write; each literal or raw byte gives one write. A repeat byte
// gives its 2 to SEGMENT_BYTES writes at one per cycle, the byte channel
// stalled meanwhile. The rate is set by the single output register: one
// write per cycle when the write channel does not stall. A run that would
// overrun its segment gives one beat with overrun_error set, after which
// every byte is taken and dropped; the same holds after the beat with
// image_done set.
module packbits_bitplane_image_decoder_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      byte_valid,
    output logic                           byte_stall,
    input  wire logic [7:0]                byte_value,
    output logic                           write_valid,
    input  wire logic                      write_stall,
    output logic [pbd_pkg::ADDR_W-1:0]     write_address,
    output logic [7:0]                     write_data,
    output logic                           last_of_run,
    output logic                           image_done,
    output logic                           overrun_error
);
    import pbd_pkg::*;

    pbd_cmd_t  cmd;
    pbd_stat_t stat;

    pbd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    pbd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_value    (byte_value),
        .cmd           (cmd),
        .stat          (stat),
        .write_valid   (write_valid),
        .write_stall   (write_stall),
        .write_address (write_address),
        .write_data    (write_data),
        .last_of_run   (last_of_run),
        .image_done    (image_done),
        .overrun_error (overrun_error)
    );

endmodule

`default_nettype wire

>>> tb/packbits_bitplane_image_decoder_top_tb.sv
// Testbench for packbits_bitplane_image_decoder_top: byte stream in, memory writes out.
// Depends on pbd_pkg and the decoder RTL. Expected writes come from a local decoder model.
`timescale 1ns / 1ps

module packbits_bitplane_image_decoder_top_tb;

    import pbd_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_BYTES = 360;

    typedef enum logic [2:0] {
        ST_TYPE, ST_HEADER, ST_CONTROL, ST_REPEAT, ST_LITERAL, ST_RAW, ST_DONE, ST_HALT
    } dec_phase_e;

    typedef enum logic [1:0] {
        PLAN_RAW, PLAN_PACKED_OVERRUN
    } run_plan_e;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              last_flag;
        logic              done_flag;
        logic              err_flag;
    } write_beat_t;

    logic              clk;
    logic              rst_n;
    logic              byte_valid;
    logic              byte_stall;
    logic [7:0]        byte_value;
    logic              write_valid;
    logic              write_stall;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
    logic              last_of_run;
    logic              image_done;
    logic              overrun_error;

    // decoder state as seen by the predictor
    dec_phase_e        ph;
    logic [5:0]        hdr_left;
    logic [7:0]        run_left;
    logic [ADDR_W-1:0] wptr;
    logic              odd;
    logic [5:0]        seg_fill;
    logic [1:0]        plane;
    logic [7:0]        line;
    logic              packed_mode;
    logic [ADDR_W-1:0] raw_ptr;

    write_beat_t expected_writes[$];
    write_beat_t exp_w;

    run_plan_e plan;
    int  fail_count;
    int  bytes_sent;
    int  writes_checked;
    int  idle_cycles;
    int  sink_hold_cycles;
    bit  sender_idle_on;
    bit  sink_idle_on;

    packbits_bitplane_image_decoder_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_value    (byte_value),
        .write_valid   (write_valid),
        .write_stall   (write_stall),
        .write_address (write_address),
        .write_data    (write_data),
        .last_of_run   (last_of_run),
        .image_done    (image_done),
        .overrun_error (overrun_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    function automatic void reset_decoder_state();
        ph          = ST_TYPE;
        hdr_left    = 6'(HEADER_BYTES);
        run_left    = '0;
        wptr        = '0;
        odd         = 1'b0;
        seg_fill    = '0;
        plane       = '0;
        line        = '0;
        packed_mode = 1'b0;
        raw_ptr     = '0;
    endfunction

    // One decoded byte: interleaved address, then segment / plane / line advance.
    function automatic void place_byte(input logic [7:0] d, input logic last);
        write_beat_t w;
        w.addr      = wptr;
        w.data      = d;
        w.last_flag = last;
        w.done_flag = 1'b0;
        w.err_flag  = 1'b0;
        wptr = wptr + (odd ? ADDR_W'(7) : ADDR_W'(1));
        odd  = ~odd;
        seg_fill++;
        if (seg_fill == SEGMENT_BYTES)
        begin
            seg_fill = '0;
            wptr  = wptr - ADDR_W'(LINE_BYTES) + ADDR_W'(2);
            plane = plane + 2'd1;
            if (plane == 2'd0)
            begin
                line = line + 8'd1;
                wptr = wptr + ADDR_W'(LINE_BYTES) - ADDR_W'(8);
                if (line == LINES)
                begin
                    w.done_flag = 1'b1;
                    ph = ST_DONE;
                end
            end
        end
        expected_writes.push_back(w);
    endfunction

    function automatic void predict_writes(input logic [7:0] b);
        int          n;
        write_beat_t w;
        case (ph)
            ST_TYPE:
            begin
                packed_mode = (b == TYPE_COMPRESSED);
                hdr_left    = 6'(HEADER_BYTES);
                ph          = ST_HEADER;
            end
            ST_HEADER:
            begin
                if (hdr_left > 0)
                    hdr_left--;
                if (hdr_left == 0)
                    ph = packed_mode ? ST_CONTROL : ST_RAW;
            end
            ST_CONTROL:
            begin
                n = b[7] ? 257 - int'(b) : int'(b) + 1;
                if (int'(seg_fill) + n > SEGMENT_BYTES)
                begin
                    w = '0;
                    w.last_flag = 1'b1;
                    w.err_flag  = 1'b1;
                    expected_writes.push_back(w);
                    ph = ST_HALT;
                end
                else
                begin
                    run_left = 8'(n);
                    ph = b[7] ? ST_REPEAT : ST_LITERAL;
                end
            end
            ST_REPEAT:
            begin
                n = int'(run_left);
                run_left = '0;
                ph = ST_CONTROL;
                for (int k = 0; k < n; k++)
                    place_byte(b, k == n - 1);
            end
            ST_LITERAL:
            begin
                if (run_left > 0)
                    run_left--;
                if (run_left == 0)
                    ph = ST_CONTROL;
                place_byte(b, 1'b1);
            end
            ST_RAW:
            begin
                w.addr      = raw_ptr;
                w.data      = b;
                w.last_flag = 1'b1;
                w.done_flag = (raw_ptr == ADDR_W'(ADDR_SPAN - 1));
                w.err_flag  = 1'b0;
                raw_ptr = raw_ptr + ADDR_W'(1);
                if (w.done_flag)
                    ph = ST_DONE;
                expected_writes.push_back(w);
            end
            default: ;
        endcase
    endfunction

    task automatic sender_gap(input int n);
        @(negedge clk);
        byte_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Offer one beat, hold it until taken, then predict its writes.
    task automatic send_byte(input logic [7:0] b);
        if (sender_idle_on && $urandom_range(0, 7) == 0)
            sender_gap($urandom_range(1, 19));
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_value <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
        predict_writes(b);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_literal_run(input int n);
        send_byte(8'(n - 1));
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_repeat_run(input int n, input logic [7:0] d);
        send_byte(8'(257 - n));
        send_byte(d);
    endtask

    task automatic test_file_header();
        logic [7:0] type_byte;
        if (plan == PLAN_RAW)
        begin
            case ($urandom_range(0, 3))
                0: type_byte = 8'h00;
                1: type_byte = 8'hFF;
                2: type_byte = 8'h81;
                default:
                begin
                    type_byte = 8'($urandom_range(0, 255));
                    if (type_byte == TYPE_COMPRESSED)
                        type_byte = 8'h7F;
                end
            endcase
        end
        else
            type_byte = TYPE_COMPRESSED;
        send_byte(type_byte);
        // header content is skipped, so odd values here must not matter
        send_byte(TYPE_COMPRESSED);
        send_byte(8'h00);
        send_byte(8'hFF);
        repeat (HEADER_BYTES - 3) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed_runs();
        if (plan == PLAN_RAW)
        begin
            send_byte(8'h00);
            send_byte(8'hFF);
            send_byte(8'h80);
            send_byte(8'h7F);
            send_byte(8'h01);
            send_byte(8'hFE);
            send_byte(8'h55);
            send_byte(8'hAA);
        end
        else
        begin
            send_repeat_run(SEGMENT_BYTES, 8'hA5);   // longest repeat, exactly one segment
            send_byte(8'h00);                        // single literal
            send_byte(8'h00);
            send_repeat_run(2, 8'hFF);               // shortest repeat
            send_byte(8'h02);
            send_byte(8'h55);
            send_byte(8'hAA);
            send_byte(8'h7F);
            send_byte(8'h01);                        // literal of two; its data bytes look like controls
            send_byte(8'h80);
            send_byte(8'hD9);
            send_repeat_run(SEGMENT_BYTES - 8, 8'h00); // fills the segment to the brim
        end
        wait_drained();
    endtask

    task automatic test_random_runs();
        int stop_at;
        int hold_at;
        int rem;
        int n;
        stop_at = bytes_sent + RANDOM_BYTES;
        hold_at = bytes_sent + $urandom_range(RANDOM_BYTES / 4, RANDOM_BYTES / 2);
        while (bytes_sent < stop_at)
        begin
            if (bytes_sent >= hold_at && hold_at > 0)
            begin
                // writes back up, the decoder fills and stalls the byte side
                sink_hold_cycles = $urandom_range(150, 300);
                hold_at = 0;
            end
            if (plan == PLAN_RAW)
                send_byte(8'($urandom_range(0, 255)));
            else
            begin
                rem = SEGMENT_BYTES - int'(seg_fill);
                if ($urandom_range(0, 3) == 0)
                    n = $urandom_range(1, rem);
                else
                    n = $urandom_range(1, rem < 6 ? rem : 6);
                if (n == 1 || $urandom_range(0, 1) == 0)
                    send_literal_run(n);
                else
                    send_repeat_run(n, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_image_end();
        int rem;
        logic [7:0] ctrl;
        sender_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        case (plan)
            // a full raw image is far longer than this run; the tail goes on writing
            PLAN_RAW: ;
            default:
            begin
                rem = SEGMENT_BYTES - int'(seg_fill);
                if ($urandom_range(0, 1))
                    ctrl = $urandom_range(0, 1) ? 8'(rem) : 8'(256 - rem); // one past the edge
                else if ($urandom_range(0, 1))
                    ctrl = 8'($urandom_range(rem, 127));
                else
                    ctrl = 8'($urandom_range(128, 256 - rem));
                send_byte(ctrl);
            end
        endcase
    endtask

    task automatic test_ignored_tail();
        repeat (8) send_byte(8'($urandom_range(0, 255)));
    endtask

    // write side: random stall bursts, plus one long hold on request
    initial
    begin
        write_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                write_stall <= 1'b1;
                repeat (sink_hold_cycles) @(negedge clk);
                sink_hold_cycles = 0;
                write_stall <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 9) == 0)
            begin
                write_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                write_stall <= 1'b0;
            end
            else
                write_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && write_valid && !write_stall)
        begin
            writes_checked++;
            if (expected_writes.size() == 0)
                note_failure($sformatf("write with nothing expected: addr %0h data %0h",
                                       write_address, write_data));
            else
            begin
                exp_w = expected_writes.pop_front();
                if (write_address !== exp_w.addr || write_data !== exp_w.data
                    || last_of_run !== exp_w.last_flag || image_done !== exp_w.done_flag
                    || overrun_error !== exp_w.err_flag)
                    note_failure($sformatf(
                        "beat %0d exp addr %0h data %0h last %0b done %0b err %0b, got %0h %0h %0b %0b %0b",
                        writes_checked, exp_w.addr, exp_w.data, exp_w.last_flag,
                        exp_w.done_flag, exp_w.err_flag, write_address, write_data,
                        last_of_run, image_done, overrun_error));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (write_valid && !write_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without a beat", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        byte_valid       = 1'b0;
        byte_value       = 8'h00;
        fail_count       = 0;
        bytes_sent       = 0;
        writes_checked   = 0;
        idle_cycles      = 0;
        sink_hold_cycles = 0;
        sender_idle_on   = 1'b1;
        sink_idle_on     = 1'b1;
        reset_decoder_state();
        case ($urandom_range(0, 7))
            0, 1, 2: plan = PLAN_RAW;
            default: plan = PLAN_PACKED_OVERRUN;
        endcase
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_file_header();
        test_directed_runs();
        test_random_runs();
        test_image_end();
        test_ignored_tail();

        @(negedge clk);
        byte_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("run plan %s: %0d byte beats in, %0d write beats checked, %0d failures",
                 plan.name(), bytes_sent, writes_checked, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
